### rtl/core/irh_avg_pkg.sv
package irh_avg_pkg;

    // Field widths
    localparam int THR_W     = 10;
    localparam int BASE_W    = 10;
    localparam int SPACING_W = 8;
    localparam int READING_W = 10;
    localparam int COUNT_W   = 16;
    localparam int HEIGHT_W  = 13;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_BASE      = 2'd1;
    localparam logic [1:0] REG_SPACING   = 2'd2;

    // Register reset values
    localparam logic [THR_W-1:0]     THRESHOLD_RST = 10'd1010;
    localparam logic [BASE_W-1:0]    BASE_RST      = 10'd50;
    localparam logic [SPACING_W-1:0] SPACING_RST   = 8'd20;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

### rtl/core/ir_array_height_averager.sv
// Non-closing words: accepted back to back, one per cycle, while the sequencer is idle.
// Closing word (last sensor): accepted, then the sum is updated, then a restoring divide
// runs (one quotient bit per cycle), then the output register is loaded once the receiver
// no longer holds off the previous result word; input stalls meanwhile.
// Reset is synchronous, active low: sum, scan position and registers return to defaults.
module ir_array_height_averager #(
    parameter int NUM_SENSORS = 8,
    parameter int SUM_BITS    = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [irh_avg_pkg::READING_W-1:0]   i_reading,
    input  logic                                i_last_sensor,
    input  logic [irh_avg_pkg::COUNT_W-1:0]     i_sample_count,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [irh_avg_pkg::HEIGHT_W-1:0]    o_scan_height_mm,
    output logic [irh_avg_pkg::HEIGHT_W-1:0]    o_average_height_mm,
    output logic                                o_sum_saturated,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [irh_avg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [irh_avg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [irh_avg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                pready
);
    import irh_avg_pkg::*;

    localparam int POS_W = $clog2(NUM_SENSORS + 1);
    localparam int CNT_W = $clog2(SUM_BITS);

    // Registers
    t_state                 r_state, n_state;
    logic [THR_W-1:0]       r_threshold;
    logic [BASE_W-1:0]      r_base;
    logic [SPACING_W-1:0]   r_spacing;

    logic [POS_W-1:0]       r_pos, n_pos;
    logic [POS_W-1:0]       r_hi, n_hi;
    logic [SUM_BITS-1:0]    r_sum, n_sum;
    logic [HEIGHT_W-1:0]    r_height;
    logic                   r_clear;
    logic [COUNT_W-1:0]     r_divisor;
    logic [COUNT_W-1:0]     r_rem;
    logic [SUM_BITS-1:0]    r_quot;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_sat;

    logic                   r_out_valid;
    logic [HEIGHT_W-1:0]    r_out_height;
    logic [HEIGHT_W-1:0]    r_out_avg;
    logic                   r_out_sat;

    logic                   w_in_acc;
    logic                   w_cfg_wr;
    logic                   w_out_free;
    logic [HEIGHT_W-1:0]    w_height;
    logic [SUM_BITS-1:0]    w_sum_base;
    logic [SUM_BITS:0]      w_sum_add;
    logic [COUNT_W:0]       w_rem_shift;
    logic [COUNT_W:0]       w_rem_diff;
    logic                   w_ge;
    logic [HEIGHT_W-1:0]    w_avg;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Configuration writes and reads
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_base      <= BASE_RST;
            r_spacing   <= SPACING_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_THRESHOLD: r_threshold <= pwdata[THR_W-1:0];
                REG_BASE:      r_base      <= pwdata[BASE_W-1:0];
                REG_SPACING:   r_spacing   <= pwdata[SPACING_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_THRESHOLD: prdata = APB_DATA_W'(r_threshold);
            REG_BASE:      prdata = APB_DATA_W'(r_base);
            REG_SPACING:   prdata = APB_DATA_W'(r_spacing);
            default:       prdata = '0;
        endcase
    end

    // Scan tracking: position and highest active sensor for this word
    always_comb begin
        n_pos = r_pos;
        n_hi  = r_hi;
        if (r_pos < POS_W'(NUM_SENSORS)) begin
            if (i_reading >= r_threshold) begin
                n_hi = r_pos + 1'b1;
            end
            n_pos = r_pos + 1'b1;
        end
    end

    // Scan height from highest active sensor
    assign w_height = (n_hi == '0) ? '0 :
                      HEIGHT_W'(r_base)
                      + HEIGHT_W'(HEIGHT_W'(n_hi - 1'b1) * HEIGHT_W'(r_spacing));

    // Saturating sum update
    assign w_sum_base = r_clear ? '0 : r_sum;
    assign w_sum_add  = {1'b0, w_sum_base} + (SUM_BITS + 1)'(r_height);
    assign n_sum      = w_sum_add[SUM_BITS] ? '1 : w_sum_add[SUM_BITS-1:0];

    // Restoring divide step
    assign w_rem_shift = {r_rem, r_quot[SUM_BITS-1]};
    assign w_rem_diff  = w_rem_shift - {1'b0, r_divisor};
    assign w_ge        = (w_rem_shift >= {1'b0, r_divisor});

    // Average clamp
    assign w_avg = (|r_quot[SUM_BITS-1:HEIGHT_W]) ? '1 : r_quot[HEIGHT_W-1:0];

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_last_sensor) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(SUM_BITS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Scan state and running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_hi  <= '0;
            r_sum <= '0;
        end else begin
            if (w_in_acc) begin
                if (i_last_sensor) begin
                    r_pos <= '0;
                    r_hi  <= '0;
                end else begin
                    r_pos <= n_pos;
                    r_hi  <= n_hi;
                end
            end
            if (r_state == ST_SUM) begin
                r_sum <= n_sum;
            end
        end
    end

    // Datapath: height capture, divider operands
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_last_sensor) begin
            r_height  <= w_height;
            r_clear   <= (i_sample_count == '0);
            r_divisor <= (i_sample_count == '0) ? COUNT_W'(1) : i_sample_count;
        end
        unique case (r_state)
            ST_SUM: begin
                r_quot <= n_sum;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_sat  <= (n_sum == '1);
            end
            ST_DIV: begin
                r_rem  <= w_ge ? w_rem_diff[COUNT_W-1:0] : w_rem_shift[COUNT_W-1:0];
                r_quot <= {r_quot[SUM_BITS-2:0], w_ge};
                r_cnt  <= r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            r_out_height <= r_height;
            r_out_avg    <= w_avg;
            r_out_sat    <= r_sat;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_scan_height_mm    = r_out_height;
    assign o_average_height_mm = r_out_avg;
    assign o_sum_saturated     = r_out_sat;

`ifndef SYNTH
    // scan position never runs past the sensor count
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(NUM_SENSORS))
        else $error("scan position beyond sensor count");

    // highest active sensor never above sensors seen
    a_hi_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hi <= r_pos)
        else $error("highest active above scan position");

    // divider remainder stays below divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_divisor))
        else $error("divide remainder out of range");

    // a new result only comes from the final sequencer state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result word without finished divide");
`endif

endmodule
